FILE: design/ipab_pkg.sv
package ipab_pkg;

    // Alphabet geometry (fixed by the 2 x 64-bit alphabet registers)
    localparam int MAX_RADIX = 16;
    localparam int DIGIT_W   = $clog2(MAX_RADIX);
    localparam int RADIX_W   = 5;
    localparam int CFG_IDX_W = 2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Classified character word, front -> back
    typedef struct packed {
        logic               is_zero;
        logic               is_blank;
        logic               is_plus;
        logic               is_minus;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
        logic [RADIX_W-1:0] radix;
        logic               bad_alpha;
        logic               last;
    } ipab_entry_t;

endpackage

FILE: design/ipab_front.sv
module ipab_front
    import ipab_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // config writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    // character in
    input  logic [7:0]           text_byte,
    input  logic                 end_of_string,
    output ipab_entry_t          entry
);

    logic [RADIX_W-1:0] radix_reg;
    logic [63:0]        alpha_lo_reg;
    logic [63:0]        alpha_hi_reg;

    logic [127:0]       alphabet;
    logic [7:0]         ch     [MAX_RADIX];
    logic [MAX_RADIX-1:0] in_use;
    logic               bad;
    logic               hit;
    logic [DIGIT_W-1:0] idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg    <= '0;
            alpha_lo_reg <= '0;
            alpha_hi_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_RADIX_LENGTH:  radix_reg    <= cfg_data[RADIX_W-1:0];
                CFG_ALPHABET_LOW:  alpha_lo_reg <= cfg_data;
                CFG_ALPHABET_HIGH: alpha_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign alphabet = {alpha_hi_reg, alpha_lo_reg};

    always_comb begin
        for (int i = 0; i < MAX_RADIX; i++) begin
            ch[i]     = alphabet[i*8 +: 8];
            in_use[i] = RADIX_W'(i) < radix_reg;
        end
    end

    // Alphabet check: length, forbidden characters, repeats
    always_comb begin
        bad = (radix_reg <= RADIX_W'(1)) || (radix_reg > RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++) begin
            if (in_use[i] && (ch[i] <= CHAR_SPACE || ch[i] >= CHAR_DEL ||
                              ch[i] == CHAR_PLUS || ch[i] == CHAR_MINUS)) begin
                bad = 1'b1;
            end
            for (int j = 0; j < i; j++) begin
                if (in_use[i] && ch[i] == ch[j]) begin
                    bad = 1'b1;
                end
            end
        end
    end

    // Digit lookup, lowest index wins
    always_comb begin
        hit = 1'b0;
        idx = '0;
        for (int i = MAX_RADIX - 1; i >= 0; i--) begin
            if (in_use[i] && ch[i] == text_byte) begin
                hit = 1'b1;
                idx = DIGIT_W'(i);
            end
        end
    end

    always_comb begin
        entry.is_zero   = (text_byte == CHAR_NUL);
        entry.is_blank  = (text_byte != CHAR_NUL) &&
                          (text_byte <= CHAR_SPACE || text_byte >= CHAR_DEL);
        entry.is_plus   = (text_byte == CHAR_PLUS);
        entry.is_minus  = (text_byte == CHAR_MINUS);
        entry.is_digit  = hit;
        entry.digit     = idx;
        entry.radix     = radix_reg;
        entry.bad_alpha = bad;
        entry.last      = end_of_string;
    end

endmodule

FILE: design/ipab_queue.sv
module ipab_queue
    import ipab_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  ipab_entry_t in_entry,
    output logic        out_valid,
    input  logic        out_pop,
    output ipab_entry_t out_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ipab_entry_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_entry = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_entry;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: design/ipab_back.sv
module ipab_back
    import ipab_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  ipab_entry_t q_entry,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_value,
    output logic        out_overflow,
    output logic        out_bad
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [31:0] mag_reg, mag_next;
    logic        ovf_reg, ovf_next;
    logic        valid_reg;
    logic [31:0] value_reg;
    logic        ovf_out_reg, bad_out_reg;

    logic [36:0] acc;
    logic [36:0] limit;
    logic        out_free;
    logic [31:0] result;

    assign out_free = !valid_reg || out_ready;
    assign q_pop    = q_valid && (!q_entry.last || out_free);

    // one multiply-add per character
    assign acc = 37'(mag_reg) * 37'(q_entry.radix) + 37'(q_entry.digit);

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        limit      = '0;

        if (phase_next == PH_SKIP) begin
            if (q_entry.is_zero) begin
                phase_next = PH_DONE;
            end else if (!q_entry.is_blank) begin
                phase_next = PH_SIGN;
            end
        end
        if (phase_next == PH_SIGN) begin
            if (q_entry.is_plus || q_entry.is_minus) begin
                neg_next = neg_reg || q_entry.is_minus;
            end else begin
                phase_next = PH_DIGITS;
            end
        end
        if (phase_next == PH_DIGITS) begin
            limit = neg_next ? 37'h0_8000_0000 : 37'h0_7FFF_FFFF;
            if (q_entry.is_zero || !q_entry.is_digit) begin
                phase_next = PH_DONE;
            end else if (acc > limit) begin
                ovf_next   = 1'b1;
                phase_next = PH_DONE;
            end else begin
                mag_next = acc[31:0];
            end
        end

        if (q_entry.bad_alpha || ovf_next) begin
            result = '0;
        end else begin
            result = neg_next ? (32'd0 - mag_next) : mag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (q_pop && q_entry.last) begin
                phase_reg   <= PH_SKIP;
                neg_reg     <= 1'b0;
                mag_reg     <= '0;
                ovf_reg     <= 1'b0;
                valid_reg   <= 1'b1;
                value_reg   <= result;
                ovf_out_reg <= ovf_next && !q_entry.bad_alpha;
                bad_out_reg <= q_entry.bad_alpha;
            end else begin
                if (q_pop) begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    mag_reg   <= mag_next;
                    ovf_reg   <= ovf_next;
                end
                if (valid_reg && out_ready) begin
                    valid_reg <= 1'b0;
                end
            end
        end
    end

    assign out_valid    = valid_reg;
    assign out_value    = value_reg;
    assign out_overflow = ovf_out_reg;
    assign out_bad      = bad_out_reg;

endmodule

FILE: design/integer_parse_any_base_unit.sv
// String to signed 32-bit integer converter with a configurable digit alphabet.
//
// s_ channel: one character word per ready cycle; s_tlast marks the last character
// of a string. The result word for that string appears on the m_ channel:
// m_tdata is the signed value, m_tuser flags overflow and a bad alphabet.
// cfg_ channel: register writes (radix length, alphabet low, alphabet high),
// always ready (unchecked); the user must see them taken while no string is in flight.
//
// Throughput: one character per cycle, as long as s_tready stays high. The
// front classifies each byte against the 16-entry alphabet compare bank in
// the accept cycle; the back runs one 32x5 multiply-add per character. With
// the queue empty ahead of it, the last character is written into the queue,
// then popped by the back into the result register, which raises m_tvalid;
// words queued ahead of it are popped first.
// Reset clears the config registers, the queue and the parse state.
// If the receiver stalls, the result waits in the output register while the
// front keeps taking characters into the queue; s_tready drops only when
// the queue fills behind a held last character.
module integer_parse_any_base_unit
    import ipab_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // character in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [7:0] text_byte
    input  logic                 s_tlast,    // end_of_string
    // result out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,    // [31:0] parsed_value (signed)
    output logic [1:0]           m_tuser,    // [0] overflowed, [1] bad_alphabet
    // config writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    ipab_entry_t front_entry;
    ipab_entry_t q_entry;
    logic        q_valid;
    logic        q_pop;
    logic        res_ovf;
    logic        res_bad;

    assign cfg_ready = 1'b1;

    ipab_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .text_byte     (s_tdata),
        .end_of_string (s_tlast),
        .entry         (front_entry)
    );

    ipab_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_entry  (front_entry),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_entry (q_entry)
    );

    ipab_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_value    (m_tdata),
        .out_overflow (res_ovf),
        .out_bad      (res_bad)
    );

    assign m_tuser = {res_bad, res_ovf};

endmodule

FILE: tb/tb_integer_parse_any_base_unit.sv
`timescale 1ns / 1ps

module tb_integer_parse_any_base_unit;
    import ipab_pkg::*;

    localparam int         WATCHDOG_CYCLES  = 2000;
    localparam int         LONG_HOLD_CYCLES = 400;
    localparam logic [7:0] CHAR_COMMA       = 8'h2C;

    typedef enum logic [1:0] {
        SKIP_BLANKS,
        READ_SIGNS,
        READ_DIGITS,
        NUMBER_DONE
    } parse_phase_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               overflowed;
        logic               bad_alphabet;
    } parse_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;     // [7:0] text_byte
    logic                 s_tlast   = 1'b0;      // end_of_string
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;               // [31:0] parsed_value
    logic [1:0]           m_tuser;               // [0] overflowed, [1] bad_alphabet
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data  = '0;

    // shadow of the parser: configuration and per-string state
    logic [4:0]    cfg_radix    = '0;
    logic [63:0]   cfg_alpha_lo = '0;
    logic [63:0]   cfg_alpha_hi = '0;
    parse_phase_t  ph           = SKIP_BLANKS;
    logic          neg_seen     = 1'b0;
    logic [31:0]   mag          = '0;
    logic          ovf_seen     = 1'b0;

    parse_result_t pending_results[$];
    int            errors       = 0;
    int            items_sent   = 0;
    int            quiet_cycles = 0;
    bit            sender_calm  = 1'b0;
    bit            force_calm   = 1'b0;
    bit            hold_req     = 1'b0;

    always #4 aclk = ~aclk;

    integer_parse_any_base_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------
    function automatic logic [7:0] alpha_char(input int i);
        logic [63:0] w;
        w = (i < 8) ? cfg_alpha_lo : cfg_alpha_hi;
        return w[(i % 8) * 8 +: 8];
    endfunction

    function automatic int digits_in_use();
        return (cfg_radix > MAX_RADIX) ? MAX_RADIX : int'(cfg_radix);
    endfunction

    function automatic bit alphabet_ok();
        logic [7:0] c;
        if (cfg_radix <= 1 || cfg_radix > MAX_RADIX) return 1'b0;
        for (int i = 0; i < int'(cfg_radix); i++) begin
            c = alpha_char(i);
            if (c <= CHAR_SPACE || c >= CHAR_DEL || c == CHAR_PLUS || c == CHAR_MINUS)
                return 1'b0;
            for (int j = 0; j < i; j++)
                if (alpha_char(j) == c) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int digit_of(input logic [7:0] c);
        for (int i = 0; i < digits_in_use(); i++)
            if (alpha_char(i) == c) return i;
        return -1;
    endfunction

    // advance the shadow parser by one character; 1 when a result word is due
    function automatic bit take_char(input logic [7:0] c, input bit eos,
                                     output parse_result_t r);
        longint unsigned v;
        longint unsigned lim;
        int              idx;
        r = '0;
        if (ph == SKIP_BLANKS) begin
            if (c == CHAR_NUL)
                ph = NUMBER_DONE;
            else if (c > CHAR_SPACE && c < CHAR_DEL)
                ph = READ_SIGNS;
        end
        if (ph == READ_SIGNS) begin
            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                if (c == CHAR_MINUS) neg_seen = 1'b1;
            end else begin
                ph = READ_DIGITS;   // a comma lands here too, as a possible digit
            end
        end
        if (ph == READ_DIGITS) begin
            idx = digit_of(c);
            if (c == CHAR_NUL || idx < 0) begin
                ph = NUMBER_DONE;
            end else begin
                lim = neg_seen ? 64'd2147483648 : 64'd2147483647;
                v   = 64'(mag) * 64'(cfg_radix) + 64'(idx);
                if (v > lim) begin
                    ovf_seen = 1'b1;
                    ph       = NUMBER_DONE;
                end else begin
                    mag = v[31:0];
                end
            end
        end
        if (!eos) return 1'b0;
        if (!alphabet_ok())
            r.bad_alphabet = 1'b1;
        else if (ovf_seen)
            r.overflowed = 1'b1;
        else
            r.value = neg_seen ? 32'd0 - mag : mag;
        ph       = SKIP_BLANKS;
        neg_seen = 1'b0;
        mag      = '0;
        ovf_seen = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_run(input logic [7:0] chars[$]);
        int            gap;
        parse_result_t r;
        foreach (chars[i]) begin
            gap = (sender_calm || force_calm) ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= chars[i];
            s_tlast  <= (i == chars.size() - 1);
            do @(posedge aclk); while (!s_tready);
            if (take_char(chars[i], i == chars.size() - 1, r))
                pending_results.push_back(r);
            items_sent++;
        end
    endtask

    // wait for every result word, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_RADIX_LENGTH:  cfg_radix    = data[4:0];
            CFG_ALPHABET_LOW:  cfg_alpha_lo = data;
            CFG_ALPHABET_HIGH: cfg_alpha_hi = data;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [63:0] radix_word, input logic [63:0] lo,
                             input logic [63:0] hi);
        drain();
        write_reg(CFG_RADIX_LENGTH, radix_word);
        write_reg(CFG_ALPHABET_LOW, lo);
        write_reg(CFG_ALPHABET_HIGH, hi);
        cfg_valid <= 1'b0;
    endtask

    task automatic use_alphabet(input string chars, input int len);
        logic [127:0] a;
        a = '0;
        for (int i = 0; i < chars.len() && i < 16; i++)
            a[i * 8 +: 8] = chars[i];
        configure(64'(len), a[63:0], a[127:64]);
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 2))
            0:       return 8'($urandom_range(1, 32));
            1:       return CHAR_DEL;
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    // one random string: mostly blanks / signs / digits / tail, some pure noise
    task automatic send_string();
        logic [7:0]      str[$];
        logic [7:0]      digs[$];
        logic [7:0]      c;
        longint unsigned m;
        int              used;
        bit              neg;
        used        = digits_in_use();
        neg         = 1'b0;
        sender_calm = ($urandom_range(0, 4) == 0);
        if (used < 2 || $urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 10)) begin
                if (used > 0 && $urandom_range(0, 3) == 0)
                    str.push_back(alpha_char($urandom_range(0, used - 1)));
                else
                    str.push_back(8'($urandom));
            end
        end else begin
            repeat ($urandom_range(0, 3)) str.push_back(blank_char());
            if ($urandom_range(0, 29) == 0) str.push_back(CHAR_NUL);
            repeat ($urandom_range(0, 3)) begin
                c = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
                if (c == CHAR_MINUS) neg = 1'b1;
                str.push_back(c);
            end
            case ($urandom_range(0, 9))
                6, 7, 8: begin
                    // right at the signed limit, a couple either side
                    m = (neg ? 64'd2147483648 : 64'd2147483647) + $urandom_range(0, 4) - 2;
                    do begin
                        digs.push_front(alpha_char(int'(m % used)));
                        m = m / used;
                    end while (m != 0);
                    if ($urandom_range(0, 3) == 0) digs.push_front(alpha_char(0));
                    foreach (digs[i]) str.push_back(digs[i]);
                end
                9: repeat ($urandom_range(9, 40))
                    str.push_back(alpha_char($urandom_range(0, used - 1)));
                default: repeat ($urandom_range(0, 8))
                    str.push_back(alpha_char($urandom_range(0, used - 1)));
            endcase
            if ($urandom_range(0, 1)) begin
                str.push_back($urandom_range(0, 1) ? CHAR_NUL : 8'($urandom));
                repeat ($urandom_range(0, 2)) str.push_back(8'($urandom));
            end
        end
        if (str.size() == 0) str.push_back(blank_char());
        send_run(str);
    endtask

    task automatic send_items(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) send_string();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [7:0] q[$];
        q = {8'h31};                                    // "1" under the reset config
        send_run(q);
        use_alphabet("0123456789", 10);
        // blanks at both ends of the range, sign run "+-+", digits, junk after end
        q = {CHAR_SPACE, CHAR_DEL, 8'hFF, 8'h01, CHAR_PLUS, CHAR_MINUS, CHAR_PLUS,
             8'h34, 8'h32, 8'h78, 8'h39};
        send_run(q);
        q = {CHAR_NUL, 8'h35};                          // zero byte before anything
        send_run(q);
        q = {8'h37, CHAR_NUL, 8'h33};                   // zero byte ends the digits
        send_run(q);
        q = {CHAR_MINUS, CHAR_COMMA, 8'h35};            // comma ends signs, not a digit
        send_run(q);
        q = {8'h39};
        send_run(q);
        use_alphabet("0123", 1);
        q = {8'h30};
        send_run(q);
    endtask

    task automatic test_fixed_alphabets();
        use_alphabet("01", 2);
        send_items(130);
        use_alphabet("0123456789", 10);
        send_items(130);
        use_alphabet("0123456789ABCDEF", 16);
        send_items(130);
        use_alphabet(",!~aZ", 5);                       // comma as digit, printable edges
        send_items(130);
        use_alphabet("zyxwvutsrqponmlk", 16);
        send_items(130);
    endtask

    task automatic test_bad_alphabets();
        use_alphabet("0123456789", 0);
        send_items(20);
        use_alphabet("0123", 1);
        send_items(20);
        use_alphabet("0123456789ABCDEF", 17);
        send_items(20);
        use_alphabet("0123456789ABCDEF", 31);
        send_items(20);
        use_alphabet("0120", 4);                        // repeated digit
        send_items(20);
        use_alphabet("01 2", 4);                        // space in alphabet
        send_items(20);
        use_alphabet("0+12", 4);
        send_items(20);
        use_alphabet("012-", 4);
        send_items(20);
        configure(64'd3, 64'h0000_0000_007F_3130, 64'd0);   // DEL
        send_items(20);
        configure(64'd3, 64'h0000_0000_00C8_3130, 64'd0);   // high byte
        send_items(20);
    endtask

    task automatic test_random_alphabets();
        logic [127:0] a;
        logic [7:0]   c;
        int           len;
        bit           dup;
        repeat (10) begin
            if ($urandom_range(0, 3) == 0) begin
                configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
            end else begin
                len = $urandom_range(2, 16);
                a   = {$urandom, $urandom, $urandom, $urandom};
                for (int k = 0; k < len; k++) begin
                    do begin
                        c   = $urandom_range(33, 126);
                        dup = (c == CHAR_PLUS || c == CHAR_MINUS);
                        for (int j = 0; j < k; j++)
                            if (a[j * 8 +: 8] == c) dup = 1'b1;
                    end while (dup);
                    a[k * 8 +: 8] = c;
                end
                configure(64'(len), a[63:0], a[127:64]);
            end
            send_items(50);
        end
    endtask

    // receiver parks for a long stretch while the sender streams flat out
    task automatic test_long_receiver_hold();
        use_alphabet("0123456789", 10);
        force_calm = 1'b1;
        hold_req   = 1'b1;
        @(posedge aclk);
        send_items(200);
        force_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern, checking, watchdog
    // ------------------------------------------------------------------
    initial begin : result_receiver
        int stall_left;
        bit calm;
        stall_left = 0;
        calm       = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD_CYCLES;
            end else if (m_tvalid && m_tready) begin
                if ($urandom_range(0, 19) == 0) calm = !calm;
                stall_left = calm ? 0 : $urandom_range(0, 7);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic note_mismatch(input string what, input parse_result_t want,
                                 input parse_result_t got);
        errors++;
        if (errors <= 10)
            $display("mismatch (%s): expected value %0d ovf %0b bad %0b, got value %0d ovf %0b bad %0b",
                     what, want.value, want.overflowed, want.bad_alphabet,
                     got.value, got.overflowed, got.bad_alphabet);
    endtask

    always @(posedge aclk) begin : result_check
        parse_result_t want;
        parse_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.value        = m_tdata;
            got.overflowed   = m_tuser[0];
            got.bad_alphabet = m_tuser[1];
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected word", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value || got.overflowed !== want.overflowed
                        || got.bad_alphabet !== want.bad_alphabet)
                    note_mismatch("field", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("** integer_parse_any_base_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_fixed_alphabets();
        test_bad_alphabets();
        test_random_alphabets();
        test_long_receiver_hold();
        drain();
        repeat (8) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0)
            $display("** integer_parse_any_base_unit: PASSED **");
        else
            $display("** integer_parse_any_base_unit: FAILED **");
        $finish;
    end

endmodule

FILE: integer_parse_any_base_unit.f
design/ipab_pkg.sv
design/ipab_front.sv
design/ipab_queue.sv
design/ipab_back.sv
design/integer_parse_any_base_unit.sv
tb/tb_integer_parse_any_base_unit.sv
